/* design/agm_pkg.sv */
// Shared types and constants for the adjacency matrix graph store.
// Holds the request and result item structs, the operation codes and the FSM states.
// No dependencies.
package agm_pkg;

  // Width of a vertex number in an item
  localparam int VERTEX_W = 4;

  // Default vertex count of the graph
  localparam int VERTICES_DEFAULT = 16;

  // Operation selector codes
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_LIST  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Input item
  typedef struct packed {
    func_t               func;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } request_t;

  // Result item
  typedef struct packed {
    logic                is_adjacent;
    logic [VERTEX_W-1:0] neighbor;
    logic                neighbor_valid;
    logic                last;
  } result_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic set_edge;
    logic emit_single;
    logic scan_load;
    logic scan_step;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_t op;
    logic  row_empty;
    logic  scan_hit;
    logic  scan_last;
  } dp_status_t;

endpackage

/* design/agm_ctrl.sv */
// Controller state machine of the adjacency matrix graph store.
// Sequences capture, execute and row scan; depends on agm_pkg.
module agm_ctrl
  import agm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Select the next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.op == FUNC_LIST && !status.row_empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_hit && status.scan_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive the datapath commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        if (status.op == FUNC_LIST && !status.row_empty) begin
          cmd.scan_load = 1'b1;
        end else begin
          cmd.emit_single = 1'b1;
          cmd.set_edge    = (status.op == FUNC_ADD);
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // An accepted item always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A scan is only entered from execute
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ($past(state) == ST_EXEC || $past(state) == ST_SCAN))
    else $error("scan entered without execute");

  // Only one kind of result command at a time
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_single, cmd.scan_load, cmd.scan_step, cmd.capture}))
    else $error("conflicting controller commands");

endmodule

/* design/agm_datapath.sv */
// Datapath of the adjacency matrix graph store: bit matrix, row scanner, result register.
// Acts on commands from agm_ctrl; depends on agm_pkg.
module agm_datapath
  import agm_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEFAULT
)(
  input  logic       clk,
  input  logic       rst,
  input  request_t   request,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       result_strobe,
  output result_t    result
);

  // Only vertices reachable by a vertex number are stored
  localparam int ROWS  = (VERTICES < (1 << VERTEX_W)) ? VERTICES : (1 << VERTEX_W);
  localparam int IDX_W = $clog2(ROWS);

  logic [ROWS-1:0]  adj [ROWS];
  request_t         req;
  logic [ROWS-1:0]  scan_row;
  logic [IDX_W-1:0] cnt;

  logic             a_ok;
  logic             b_ok;
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] b_idx;
  logic [ROWS-1:0]  sel_row;
  logic             query_bit;
  logic [ROWS-1:0]  scan_rest;

  // Decode the captured vertex numbers
  assign a_ok      = ({1'b0, req.vertex_a} < (VERTEX_W + 1)'(ROWS));
  assign b_ok      = ({1'b0, req.vertex_b} < (VERTEX_W + 1)'(ROWS));
  assign a_idx     = req.vertex_a[IDX_W-1:0];
  assign b_idx     = req.vertex_b[IDX_W-1:0];
  assign sel_row   = a_ok ? adj[a_idx] : '0;
  assign query_bit = a_ok && b_ok && sel_row[b_idx];

  // Drop the current bit to see what remains of the row
  assign scan_rest = scan_row & ~(ROWS'(1) << cnt);

  assign status.op        = req.func;
  assign status.row_empty = (sel_row == '0);
  assign status.scan_hit  = scan_row[cnt];
  assign status.scan_last = (scan_rest == '0);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
  end

  // Clear the matrix at reset, set both symmetric bits on add edge
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        adj[r] <= '0;
      end
    end else if (cmd.set_edge && a_ok && b_ok) begin
      adj[a_idx][b_idx] <= 1'b1;
      adj[b_idx][a_idx] <= 1'b1;
    end
  end

  // Load and advance the row scanner
  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      scan_row <= sel_row;
      cnt      <= '0;
    end else if (cmd.scan_step) begin
      scan_row <= scan_rest;
      cnt      <= cnt + IDX_W'(1);
    end
  end

  // Register the result item and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_single || (cmd.scan_step && scan_row[cnt]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      result.is_adjacent    <= (req.func == FUNC_QUERY) && query_bit;
      result.neighbor       <= '0;
      result.neighbor_valid <= 1'b0;
      result.last           <= 1'b1;
    end else if (cmd.scan_step && scan_row[cnt]) begin
      result.is_adjacent    <= 1'b0;
      result.neighbor       <= VERTEX_W'(cnt);
      result.neighbor_valid <= 1'b1;
      result.last           <= (scan_rest == '0);
    end
  end

  // A scan step always has a set bit left in the row
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (scan_row != '0))
    else $error("scan stepped over an exhausted row");

  // A single result is delivered the next cycle and closes its item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_single |=> (result_strobe && result.last))
    else $error("single result missing or not marked last");

  // A listed neighbor never carries a query answer
  a_list_no_adj: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.neighbor_valid) |-> !result.is_adjacent)
    else $error("neighbor result carries a query answer");

endmodule

/* design/adjacency_matrix_graph_store.sv */
// Adjacency matrix graph store, top level. Add edge, query and unused selector: the
// result strobe is registered from the execute state and busy is high for one cycle;
// no new item is taken while busy. List neighbors: results strobe in ascending order
// during the row scan and the next item is taken once the scan ends; an empty row gives
// one closing result. The row scanner visits one column per cycle. Synchronous reset
// clears the whole matrix at once; the receiver cannot stall, results are never held.
module adjacency_matrix_graph_store
  import agm_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEFAULT
)(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     result_strobe,
  output result_t  result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence each item
  agm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the matrix and build the results
  agm_datapath #(
    .VERTICES (VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

/* tb/adjacency_matrix_graph_store_tb.sv */
// Self-checking testbench for the adjacency matrix graph store.
// Drives add, query, list and unused items and checks every result against a local graph.
// Depends on agm_pkg and the adjacency_matrix_graph_store top level.
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_tb;
  import agm_pkg::*;

  localparam int NV          = VERTICES_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 24;
  localparam int PHASE_ITEMS = 59;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     result_strobe;
  result_t  result;

  adjacency_matrix_graph_store dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_strobe(result_strobe),
    .result       (result)
  );

  // Local copy of the graph and the results it predicts
  bit [NV-1:0] adj_rows [NV];
  result_t     expected_results [$];
  request_t    pending_requests [$];

  int  send_idle_pct;
  bit  took_item;
  int  cycle_count;
  int  mismatch_count;
  int  results_checked;
  int  op_count [4];
  int  longest_list;

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Build one input item
  function automatic request_t make_request(func_t f, int a, int b);
    request_t r;
    r.func     = f;
    r.vertex_a = a[VERTEX_W-1:0];
    r.vertex_b = b[VERTEX_W-1:0];
    return r;
  endfunction

  // Update the local graph and queue the results this item causes
  task automatic predict_graph_results(request_t req);
    result_t rs;
    int      a;
    int      b;
    int      hits;
    a  = req.vertex_a;
    b  = req.vertex_b;
    rs = '0;
    rs.last = 1'b1;
    op_count[req.func]++;
    case (req.func)
      FUNC_ADD: begin
        if (a < NV && b < NV) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
        end
        expected_results.push_back(rs);
      end
      FUNC_QUERY: begin
        if (a < NV && b < NV) rs.is_adjacent = adj_rows[a][b];
        expected_results.push_back(rs);
      end
      FUNC_LIST: begin
        hits = 0;
        if (a < NV) begin
          // Emit one result per set bit, ascending
          for (int i = 0; i < NV; i++) begin
            if (adj_rows[a][i]) begin
              rs = '0;
              rs.neighbor       = i[VERTEX_W-1:0];
              rs.neighbor_valid = 1'b1;
              expected_results.push_back(rs);
              hits++;
            end
          end
        end
        if (hits == 0) begin
          rs = '0;
          rs.last = 1'b1;
          expected_results.push_back(rs);
        end else begin
          expected_results[expected_results.size()-1].last = 1'b1;
        end
        if (hits > longest_list) longest_list = hits;
      end
      default: expected_results.push_back(rs);
    endcase
  endtask

  // Compare one result with the oldest expectation
  task automatic check_graph_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] unexpected result adj=%0b nb=%0d nv=%0b last=%0b", $realtime,
                 got.is_adjacent, got.neighbor, got.neighbor_valid, got.last);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.is_adjacent !== want.is_adjacent || got.neighbor !== want.neighbor ||
          got.neighbor_valid !== want.neighbor_valid || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] result mismatch: expected adj=%0b nb=%0d nv=%0b last=%0b",
                   $realtime, want.is_adjacent, want.neighbor, want.neighbor_valid,
                   want.last);
          $display("[%0t]                  got      adj=%0b nb=%0d nv=%0b last=%0b",
                   $realtime, got.is_adjacent, got.neighbor, got.neighbor_valid,
                   got.last);
        end
      end
    end
  endtask

  // Queue one random phase: a full star around a random hub, then mixed traffic
  task automatic queue_random_phase();
    int hub;
    int order [NV];
    int j;
    int tmp;
    int r;
    func_t f;
    hub = $urandom_range(0, NV-1);
    for (int i = 0; i < NV; i++) order[i] = i;
    for (int i = NV-1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NV; i++) pending_requests.push_back(make_request(FUNC_ADD, hub, order[i]));
    pending_requests.push_back(make_request(FUNC_LIST, hub, $urandom_range(0, NV-1)));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      f = FUNC_ADD;
      else if (r < 70) f = FUNC_QUERY;
      else if (r < 94) f = FUNC_LIST;
      else             f = FUNC_NONE;
      pending_requests.push_back(make_request(f, $urandom_range(0, NV-1),
                                              $urandom_range(0, NV-1)));
    end
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: present the next item at the falling edge, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        request <= pending_requests.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record accepted items and check strobed results
  always @(posedge clk) begin
    if (rst) begin
      took_item = 1'b0;
    end else begin
      took_item = start && !busy;
      if (took_item) predict_graph_results(request);
      if (result_strobe) check_graph_result(result);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    send_idle_pct = 31;
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty rows, self-loops, corner vertices, symmetry, unused selector
    pending_requests.push_back(make_request(FUNC_LIST,  0,  0));
    pending_requests.push_back(make_request(FUNC_QUERY, 0,  0));
    pending_requests.push_back(make_request(FUNC_ADD,   0,  0));
    pending_requests.push_back(make_request(FUNC_QUERY, 0,  0));
    pending_requests.push_back(make_request(FUNC_LIST,  0,  9));
    pending_requests.push_back(make_request(FUNC_ADD,   15, 15));
    pending_requests.push_back(make_request(FUNC_ADD,   0,  15));
    pending_requests.push_back(make_request(FUNC_QUERY, 15, 0));
    pending_requests.push_back(make_request(FUNC_QUERY, 0,  15));
    pending_requests.push_back(make_request(FUNC_LIST,  0,  0));
    pending_requests.push_back(make_request(FUNC_LIST,  15, 15));
    pending_requests.push_back(make_request(FUNC_ADD,   5,  10));
    pending_requests.push_back(make_request(FUNC_QUERY, 10, 5));
    pending_requests.push_back(make_request(FUNC_QUERY, 5,  9));
    pending_requests.push_back(make_request(FUNC_LIST,  10, 0));
    pending_requests.push_back(make_request(FUNC_LIST,  7,  15));
    pending_requests.push_back(make_request(FUNC_NONE,  15, 15));
    pending_requests.push_back(make_request(FUNC_NONE,  0,  0));
    pending_requests.push_back(make_request(FUNC_ADD,   15, 1));
    pending_requests.push_back(make_request(FUNC_LIST,  15, 3));
    pending_requests.push_back(make_request(FUNC_QUERY, 1,  15));
    pending_requests.push_back(make_request(FUNC_LIST,  1,  1));

    // Random phases: sender gaps at 31%, then 56%, then none
    queue_random_phase();
    wait_for_drain();
    send_idle_pct = 56;
    queue_random_phase();
    wait_for_drain();
    send_idle_pct = 0;
    queue_random_phase();
    wait_for_drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    // Leftover expectations are failures
    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Ran %0d adds, %0d queries, %0d neighbor lists and %0d unused-selector items",
             op_count[FUNC_ADD], op_count[FUNC_QUERY], op_count[FUNC_LIST],
             op_count[FUNC_NONE]);
    $display("Checked %0d results; longest neighbor list had %0d entries",
             results_checked, longest_list);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
